>>> hdl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// No dependencies; imported by ile_step, indexed_list_engine and the testbench.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int POS_W       = 7;
    localparam int CNT_W       = 7;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;
    localparam int S_TDATA_W   = ((POS_W + VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [CNT_W-1:0] nxt;
        logic             done;
    } ile_step_t;

endpackage

>>> hdl/ile_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ile_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ile_step.sv
// Shared index step unit: moves the shift index one place and checks the end.
// Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_step
    import ile_pkg::*;
(
    input  logic [CNT_W-1:0] k,
    input  logic [CNT_W-1:0] limit,
    input  logic             down,
    output ile_step_t        res
);

    always_comb
    begin
        res.nxt  = down ? (k + CNT_W'(1)) : (k - CNT_W'(1));
        res.done = (k == limit);
    end

endmodule

>>> hdl/indexed_list_engine.sv
// Indexed list engine: bounded ordered list with insert, remove and get by position.
// A get reads the RAM; a rejected or unused command goes straight to its result; insert and
// remove shift entries and insert then writes the value; entries move one per cycle through
// the single RAM port pair. A new item is taken the cycle after its predecessor's result is
// loaded. Reset (rst_n low, asynchronous) empties the list; stored values are not cleared.
// Depends on ile_pkg, ile_ram, ile_step.
`timescale 1ns / 1ps

module indexed_list_engine
    import ile_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position[6:0], value_in[38:7], zero pad
    input  logic [CMD_W-1:0]     s_tuser,   // cmd[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // value_out[31:0], count[38:32], zero pad
    output logic [STAT_W-1:0]    m_tuser    // status[1:0]
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_GET,
        ST_RESULT
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]       k_reg, k_next;
    logic [CNT_W-1:0]       limit_reg, limit_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    status_t                stat_reg, stat_next;
    logic [VALUE_WIDTH-1:0] rval_reg, rval_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_stat_reg, out_stat_next;
    logic [VALUE_WIDTH-1:0] out_val_reg, out_val_next;
    logic [CNT_W-1:0]       out_cnt_reg, out_cnt_next;

    logic [POS_W-1:0]       in_pos;
    logic [VALUE_WIDTH-1:0] in_val;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;
    ile_step_t              step;

    assign in_pos = s_tdata[POS_W-1:0];
    assign in_val = s_tdata[POS_W +: VALUE_WIDTH];

    ile_step u_step (
        .k     (k_reg),
        .limit (limit_reg),
        .down  (cmd_reg == CMD_REMOVE),
        .res   (step)
    );

    ile_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_cnt_reg, out_val_reg});
    assign m_tuser  = out_stat_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        k_next         = k_reg;
        limit_next     = limit_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        count_next     = count_reg;
        stat_next      = stat_reg;
        rval_next      = rval_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_val_next   = out_val_reg;
        out_cnt_next   = out_cnt_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = mem_rdata;
        mem_raddr      = step.nxt[ADDR_W-1:0];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = in_pos[ADDR_W-1:0];
                if (s_tvalid)
                begin
                    cmd_next   = cmd_t'(s_tuser);
                    pos_next   = in_pos;
                    val_next   = in_val;
                    stat_next  = STAT_OK;
                    rval_next  = '0;
                    pend_next  = 1'b0;
                    state_next = ST_RESULT;
                    unique case (cmd_t'(s_tuser))
                        CMD_INSERT:
                        begin
                            if (in_pos > count_reg)
                            begin
                                stat_next = STAT_BAD_POS;
                            end
                            else if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                limit_next = in_pos;
                                state_next = ST_SHIFT;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (in_pos >= count_reg)
                            begin
                                stat_next = STAT_BAD_POS;
                            end
                            else
                            begin
                                k_next     = in_pos;
                                limit_next = count_reg - CNT_W'(1);
                                state_next = ST_SHIFT;
                            end
                        end
                        CMD_GET:
                        begin
                            if (in_pos >= count_reg)
                            begin
                                stat_next = STAT_BAD_POS;
                            end
                            else
                            begin
                                state_next = ST_GET;
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                mem_we = pend_reg;
                if (!step.done)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = k_reg[ADDR_W-1:0];
                    k_next         = step.nxt;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
            end
            ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[ADDR_W-1:0];
                mem_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_RESULT;
            end
            ST_GET:
            begin
                rval_next  = mem_rdata;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_val_next   = rval_reg;
                    out_cnt_next   = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_GET;
            pos_reg       <= '0;
            val_reg       <= '0;
            k_reg         <= '0;
            limit_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            count_reg     <= '0;
            stat_reg      <= STAT_OK;
            rval_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_stat_reg  <= STAT_OK;
            out_val_reg   <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            k_reg         <= k_next;
            limit_reg     <= limit_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            count_reg     <= count_next;
            stat_reg      <= stat_next;
            rval_reg      <= rval_next;
            out_valid_reg <= out_valid_next;
            out_stat_reg  <= out_stat_next;
            out_val_reg   <= out_val_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_reg)
        else $error("shift write still pending while taking a new transfer");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == ST_PLACE || $past(state_reg) == ST_SHIFT))
        else $error("entry count changed outside insert or remove");

    a_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && cmd_reg != CMD_GET) |-> (rval_reg == '0))
        else $error("read value set for a command other than get");
`endif

endmodule

>>> tb/sv/indexed_list_engine_tb.sv
// Testbench for indexed_list_engine: random and directed insert/remove/get streams
// checked against a scoreboard class that tracks the list contents and count.
// Depends on ile_pkg and indexed_list_engine.
`timescale 1ns / 1ps

module indexed_list_engine_tb;
    import ile_pkg::*;

    localparam int VALUE_OUT_W = 32;
    localparam int RAND_ITEMS  = 950;
    localparam int ROUND_LEN   = 90;

    typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIXED } stim_mode_t;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        status_t                status;
        logic [VALUE_OUT_W-1:0] value;
        logic [CNT_W-1:0]       count;
    } list_result_t;

    class list_scoreboard;
        logic [VALUE_WIDTH-1:0] entries [CAPACITY];
        int unsigned            fill = 0;
        list_result_t           expected_q [$];
        int unsigned            errors = 0;
        int unsigned            checked = 0;
        int unsigned            full_seen = 0;
        int unsigned            badpos_seen = 0;
        int unsigned            peak = 0;

        function void note_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                   input logic [VALUE_WIDTH-1:0] val);
            list_result_t res;
            int unsigned  k;
            res.status = STAT_OK;
            res.value  = '0;
            case (cmd)
                CMD_INSERT:
                begin
                    if (pos > fill)
                        res.status = STAT_BAD_POS;
                    else if (fill >= CAPACITY)
                        res.status = STAT_FULL;
                    else
                    begin
                        for (k = fill; k > pos; k--)
                            entries[k] = entries[k - 1];
                        entries[pos] = val;
                        fill++;
                    end
                end
                CMD_REMOVE:
                begin
                    if (pos >= fill)
                        res.status = STAT_BAD_POS;
                    else
                    begin
                        for (k = pos; k + 1 < fill; k++)
                            entries[k] = entries[k + 1];
                        fill--;
                    end
                end
                CMD_GET:
                begin
                    if (pos >= fill)
                        res.status = STAT_BAD_POS;
                    else
                        res.value = VALUE_OUT_W'(entries[pos]);
                end
                default:
                begin
                end
            endcase
            res.count = CNT_W'(fill);
            if (res.status == STAT_FULL)
                full_seen++;
            if (res.status == STAT_BAD_POS)
                badpos_seen++;
            if (fill > peak)
                peak = fill;
            expected_q.push_back(res);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        task report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
            errors++;
            $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
        endtask

        task check_result(input logic [STAT_W-1:0] st, input logic [VALUE_OUT_W-1:0] v,
                          input logic [CNT_W-1:0] c);
            list_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with nothing pending, status", 32'd0, 32'(st));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (st !== want.status)
                report_mismatch("status", 32'(want.status), 32'(st));
            if (v !== want.value)
                report_mismatch("value_out", want.value, v);
            if (c !== want.count)
                report_mismatch("count", 32'(want.count), 32'(c));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    list_scoreboard sb = new();
    int unsigned    sent = 0;

    indexed_list_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // position[6:0], value_in[38:7], zero pad
        .s_tuser  (s_tuser),    // cmd[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // value_out[31:0], count[38:32], zero pad
        .m_tuser  (m_tuser)     // status[1:0]
    );

    always #2 clk = ~clk;

    task send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                      input logic [VALUE_WIDTH-1:0] val);
        int gap;
        gap = ((sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({val, pos});
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        sb.note_command(cmd, pos, val);
        sent++;
    endtask

    // result side: random stalls, idle-free stretches, one long hold-off
    initial
    begin
        int unsigned rx_count;
        int          stall;
        rx_count = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_count == 200)
                stall = 300;
            else if ((rx_count / 50) % 3 == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tuser, m_tdata[VALUE_OUT_W-1:0], m_tdata[VALUE_OUT_W +: CNT_W]);
            rx_count++;
        end
    end

    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int unsigned            rand_items;
        int unsigned            round;
        stim_mode_t             mode;
        int                     roll;
        int                     ins_pct;
        int                     rem_pct;
        logic [CMD_W-1:0]       cmd;
        logic [POS_W-1:0]       pos;
        logic [VALUE_WIDTH-1:0] val;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, past-end positions, unused command, value extremes
        send_command(CMD_GET,    7'd0,   $urandom);
        send_command(CMD_REMOVE, 7'd0,   $urandom);
        send_command(CMD_INSERT, 7'd1,   $urandom);
        send_command(CMD_UNUSED, 7'd5,   $urandom);
        send_command(CMD_INSERT, 7'd0,   32'h0000_0000);
        send_command(CMD_INSERT, 7'd1,   32'hFFFF_FFFF);
        send_command(CMD_INSERT, 7'd1,   32'hA5A5_5A5A);
        send_command(CMD_INSERT, 7'd0,   32'h1234_5678);
        for (int i = 0; i < 4; i++)
            send_command(CMD_GET, POS_W'(i), $urandom);
        send_command(CMD_GET,    7'd4,   $urandom);
        send_command(CMD_GET,    7'd127, $urandom);
        send_command(CMD_INSERT, 7'd5,   $urandom);
        send_command(CMD_INSERT, 7'd127, 32'hFFFF_FFFF);
        send_command(CMD_REMOVE, 7'd3,   $urandom);
        send_command(CMD_REMOVE, 7'd0,   $urandom);
        send_command(CMD_REMOVE, 7'd2,   $urandom);
        send_command(CMD_GET,    7'd1,   $urandom);
        send_command(CMD_UNUSED, 7'd127, 32'hFFFF_FFFF);
        send_command(CMD_REMOVE, 7'd1,   $urandom);
        send_command(CMD_REMOVE, 7'd0,   $urandom);
        send_command(CMD_GET,    7'd0,   $urandom);

        // rounds that push toward capacity, toward empty, and mix in between
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            round = rand_items / ROUND_LEN;
            case (round % 4)
                0:       mode = MODE_FILL;
                2:       mode = MODE_DRAIN;
                default: mode = MODE_MIXED;
            endcase
            ins_pct = (mode == MODE_FILL) ? 88 : (mode == MODE_DRAIN) ? 10 : 45;
            rem_pct = (mode == MODE_FILL) ? 4  : (mode == MODE_DRAIN) ? 80 : 35;

            case ($urandom_range(0, 9))
                0:       val = '0;
                1:       val = '1;
                default: val = $urandom;
            endcase

            if ($urandom_range(0, 99) < 8)
            begin
                cmd = CMD_W'($urandom_range(0, 3));
                pos = POS_W'($urandom_range(0, 127));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < ins_pct)
                begin
                    cmd = CMD_INSERT;
                    case ($urandom_range(0, 5))
                        0:       pos = '0;
                        1:       pos = POS_W'(sb.fill);
                        default: pos = POS_W'($urandom_range(0, sb.fill));
                    endcase
                end
                else
                begin
                    cmd = (roll < ins_pct + rem_pct) ? CMD_REMOVE : CMD_GET;
                    if (sb.fill == 0)
                        pos = '0;
                    else
                        pos = POS_W'($urandom_range(0, sb.fill - 1));
                end
            end

            send_command(cmd, pos, val);
            if (cmd != CMD_UNUSED)
                rand_items++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (sb.pending() != 0)
            sb.report_mismatch("results never delivered", 32'd0, sb.pending());

        $display("Covered %0d commands, %0d results checked, peak list size %0d.",
                 sent, sb.checked, sb.peak);
        $display("Rejections seen: %0d full list, %0d bad position.",
                 sb.full_seen, sb.badpos_seen);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
